/* rtl/rtip_pkg.sv */
// ----------------------------------------------------------------------------
// rtip_pkg: shared types and constants
// Character codes, the classified-character record and the queue sizing
// used by the front and back halves of the integer text parser.
// ----------------------------------------------------------------------------
package rtip_pkg;

    localparam int OUT_WIDTH   = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CASE_FOLD = 8'h20;
    localparam logic [7:0] ALPHA_GAP = 8'd7;
    localparam logic [7:0] ALPHA_MIN = 8'd17;

    // One character after classification.
    typedef struct packed {
        logic       delim;      // at or below space
        logic       space;
        logic       minus;
        logic       zero;
        logic       nonzero;    // '1'..'9'
        logic       dec;        // '0'..'9'
        logic       lc_x;
        logic       lc_b;
        logic [7:0] digit;      // mapped digit value
    } t_char_class;

endpackage

/* rtl/rtip_front.sv */
// ----------------------------------------------------------------------------
// rtip_front: character classifier and request queue
// Classifies each incoming byte and stores the result in a short FIFO
// that feeds the back end.
// ----------------------------------------------------------------------------
module rtip_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_ch,
    output logic                   o_q_valid,
    input  logic                   i_q_ready,
    output rtip_pkg::t_char_class  o_q_data
);

    rtip_pkg::t_char_class                r_mem [rtip_pkg::QUEUE_DEPTH];
    logic [rtip_pkg::QPTR_W-1:0]          r_wr_ptr, n_wr_ptr;
    logic [rtip_pkg::QPTR_W-1:0]          r_rd_ptr, n_rd_ptr;
    logic [rtip_pkg::QCNT_W-1:0]          r_count, n_count;
    rtip_pkg::t_char_class                w_class;
    logic [7:0]                           w_fold;
    logic [7:0]                           w_off;
    logic                                 w_push;
    logic                                 w_pop;

    always_comb begin
        w_fold = (i_ch >= rtip_pkg::CH_LOW_A) ? i_ch - rtip_pkg::CASE_FOLD : i_ch;
        w_off  = w_fold - rtip_pkg::CH_ZERO;
        w_class.digit   = (w_off >= rtip_pkg::ALPHA_MIN) ? w_off - rtip_pkg::ALPHA_GAP : w_off;
        w_class.delim   = (i_ch <= rtip_pkg::CH_SPACE);
        w_class.space   = (i_ch == rtip_pkg::CH_SPACE);
        w_class.minus   = (i_ch == rtip_pkg::CH_MINUS);
        w_class.zero    = (i_ch == rtip_pkg::CH_ZERO);
        w_class.dec     = (i_ch >= rtip_pkg::CH_ZERO) && (i_ch <= rtip_pkg::CH_NINE);
        w_class.nonzero = w_class.dec && !w_class.zero;
        w_class.lc_x    = (i_ch == rtip_pkg::CH_LOW_X);
        w_class.lc_b    = (i_ch == rtip_pkg::CH_LOW_B);
    end

    assign o_ready   = (r_count != rtip_pkg::QCNT_W'(rtip_pkg::QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_data  = r_mem[r_rd_ptr];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_class;
        end
    end

endmodule

/* rtl/rtip_back.sv */
// ----------------------------------------------------------------------------
// rtip_back: token state machine and accumulator
// Consumes classified characters, tracks sign, radix and digits, and
// holds the finished result in an output register.
// ----------------------------------------------------------------------------
module rtip_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    output logic                            o_q_ready,
    input  rtip_pkg::t_char_class           i_q_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_ok,
    output logic [rtip_pkg::OUT_WIDTH-1:0]  o_value
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_SIGN, PH_ZERO, PH_DIGITS, PH_DISCARD
    } t_phase;

    typedef enum logic [1:0] {
        RX_DEC, RX_HEX, RX_BIN, RX_OCT
    } t_radix;

    t_phase                              r_phase, n_phase;
    t_radix                              r_radix, n_radix;
    logic                                r_neg, n_neg;
    logic [VALUE_WIDTH-1:0]              r_acc, n_acc;
    logic                                r_out_valid, n_out_valid;
    logic                                r_ok, n_ok;
    logic [rtip_pkg::OUT_WIDTH-1:0]      r_value, n_value;

    logic                                w_fire;
    logic [7:0]                          w_radix_val;
    logic                                w_digit_ok;
    logic                                w_oct_ok;
    logic [VALUE_WIDTH-1:0]              w_scaled;
    logic [VALUE_WIDTH-1:0]              w_acc_next;
    logic [VALUE_WIDTH-1:0]              w_signed;
    logic [VALUE_WIDTH+rtip_pkg::OUT_WIDTH-1:0] w_ext;

    assign o_q_ready = !r_out_valid || i_ready;
    assign w_fire    = i_q_valid && o_q_ready;

    always_comb begin
        case (r_radix)
            RX_HEX:  w_radix_val = 8'd16;
            RX_BIN:  w_radix_val = 8'd2;
            RX_OCT:  w_radix_val = 8'd8;
            default: w_radix_val = 8'd10;
        endcase
        case (r_radix)
            RX_HEX:  w_scaled = r_acc << 4;
            RX_BIN:  w_scaled = r_acc << 1;
            RX_OCT:  w_scaled = r_acc << 3;
            default: w_scaled = (r_acc << 3) + (r_acc << 1);
        endcase
    end

    assign w_digit_ok = (i_q_data.digit < w_radix_val);
    assign w_oct_ok   = (i_q_data.digit < 8'd8);
    assign w_acc_next = w_scaled + VALUE_WIDTH'(i_q_data.digit);
    assign w_signed   = r_neg ? '0 - r_acc : r_acc;
    assign w_ext      = {{rtip_pkg::OUT_WIDTH{1'b0}}, w_signed};

    always_comb begin
        n_phase     = r_phase;
        n_radix     = r_radix;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !i_ready;
        n_ok        = r_ok;
        n_value     = r_value;

        if (w_fire) begin
            case (r_phase)
                PH_SIGN, PH_IDLE: begin
                    if (r_phase == PH_IDLE && i_q_data.space) begin
                        // skip
                    end else if (r_phase == PH_IDLE && i_q_data.minus) begin
                        n_neg   = 1'b1;
                        n_phase = PH_SIGN;
                    end else begin
                        if (r_phase == PH_IDLE) begin
                            n_neg = 1'b0;
                        end
                        if (i_q_data.zero) begin
                            n_phase = PH_ZERO;
                        end else if (i_q_data.nonzero) begin
                            n_radix = RX_DEC;
                            n_acc   = VALUE_WIDTH'(i_q_data.digit);
                            n_phase = PH_DIGITS;
                        end else begin
                            // control byte or delimiter goes idle, other bytes discard; both fail the token
                            n_phase     = i_q_data.delim ? PH_IDLE : PH_DISCARD;
                            n_neg       = 1'b0;
                            n_radix     = RX_DEC;
                            n_acc       = '0;
                            n_out_valid = 1'b1;
                            n_ok        = 1'b0;
                            n_value     = '0;
                        end
                    end
                end
                PH_ZERO: begin
                    if (i_q_data.lc_x || i_q_data.lc_b) begin
                        n_radix = i_q_data.lc_x ? RX_HEX : RX_BIN;
                        n_acc   = '0;
                        n_phase = PH_DIGITS;
                    end else if (i_q_data.delim) begin
                        n_phase     = PH_IDLE;
                        n_neg       = 1'b0;
                        n_radix     = RX_DEC;
                        n_acc       = '0;
                        n_out_valid = 1'b1;
                        n_ok        = 1'b1;
                        n_value     = '0;
                    end else if (i_q_data.dec && w_oct_ok) begin
                        n_radix = RX_OCT;
                        n_acc   = VALUE_WIDTH'(i_q_data.digit);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase     = PH_DISCARD;
                        n_neg       = 1'b0;
                        n_radix     = RX_DEC;
                        n_acc       = '0;
                        n_out_valid = 1'b1;
                        n_ok        = 1'b0;
                        n_value     = '0;
                    end
                end
                PH_DIGITS: begin
                    if (i_q_data.delim) begin
                        n_phase     = PH_IDLE;
                        n_neg       = 1'b0;
                        n_radix     = RX_DEC;
                        n_acc       = '0;
                        n_out_valid = 1'b1;
                        n_ok        = 1'b1;
                        n_value     = w_ext[rtip_pkg::OUT_WIDTH-1:0];
                    end else if (w_digit_ok) begin
                        n_acc = w_acc_next;
                    end else begin
                        n_phase     = PH_DISCARD;
                        n_neg       = 1'b0;
                        n_radix     = RX_DEC;
                        n_acc       = '0;
                        n_out_valid = 1'b1;
                        n_ok        = 1'b0;
                        n_value     = '0;
                    end
                end
                PH_DISCARD: begin
                    if (i_q_data.delim) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_radix     <= RX_DEC;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_radix     <= n_radix;
            r_neg       <= n_neg;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok    <= n_ok;
        r_value <= n_value;
    end

    assign o_valid = r_out_valid;
    assign o_ok    = r_ok;
    assign o_value = r_value;

endmodule

/* rtl/radix_integer_text_parser_core.sv */
// ----------------------------------------------------------------------------
// radix_integer_text_parser_core: streaming integer text parser
// Parses space-delimited signed integers with 0x / 0b / leading-zero prefixes.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle when not stalled and returns one request per
// finished token (ok plus the signed value, wrapped to VALUE_WIDTH bits, then
// zero-extended or truncated to 32). Sustained rate is one byte per clock while
// the output is not stalled; the accumulator shift-add is combinational. A byte
// accepted at the input is written into the queue, then taken by the state
// machine into the output register. A four-entry queue separates classification
// from the state machine, so a stalled output backs up into the queue before the
// input stalls. No clearing pass is needed after reset.
module radix_integer_text_parser_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_ch,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_ok,
    output logic signed [31:0] o_value
);

    logic                            w_q_valid;
    logic                            w_q_ready;
    rtip_pkg::t_char_class           w_q_data;
    logic [rtip_pkg::OUT_WIDTH-1:0]  w_value;

    rtip_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_ch      (i_ch),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_data  (w_q_data)
    );

    rtip_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q_data  (w_q_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_ok      (o_ok),
        .o_value   (w_value)
    );

    assign o_value = signed'(w_value);

`ifndef SYNTHESIS
    // failed tokens always report a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_value == '0)
        else $error("nonzero value on failed request");

    // a full queue cannot be empty toward the back end
    a_full_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> w_q_valid)
        else $error("input stalled with empty queue");

    // a new result only appears after the back end consumed a character
    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_q_valid && w_q_ready))
        else $error("result without consumed character");
`endif

endmodule

/* tb/radix_integer_text_parser_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_integer_text_parser_core_tb: self-checking bench for the text parser
// Feeds a directed table of corner tokens, then ~650 random bytes made mostly
// of well-formed signed tokens in all four radixes, plus noise and corrupted
// tokens. A parser model predicts requests not set by hand; random backpressure,
// input gaps and one long output hold-off exercise the internal queue.
// ----------------------------------------------------------------------------
module radix_integer_text_parser_core_tb;

    localparam int RANDOM_CHARS = 650;
    localparam int HOLD_AT      = 220;     // char index where the long hold-off starts
    localparam int LONG_HOLD    = 200;
    localparam int CALM_TAIL    = 80;      // last chars sent with no idling
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 100000;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_SIGN, SCAN_LEAD_ZERO, SCAN_DIGITS, SCAN_SKIP
    } t_scan_phase;

    typedef enum logic [1:0] {BASE_DEC, BASE_HEX, BASE_BIN, BASE_OCT} t_base;

    // One input byte; typed rows carry the expected request written by hand.
    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        logic        has_res;
        logic        ok;
        logic [31:0] value;
    } t_char_req;

    typedef struct packed {
        logic        ok;
        logic [31:0] value;
    } t_parse_res;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [7:0]         i_ch    = '0;
    logic               i_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic               o_ok;
    logic signed [31:0] o_value;

    radix_integer_text_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_ch    (i_ch),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_ok    (o_ok),
        .o_value (o_value)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // parser model state
    t_scan_phase scan_phase = SCAN_IDLE;
    logic        scan_neg   = 1'b0;
    t_base       scan_base  = BASE_DEC;
    logic [31:0] scan_acc   = '0;

    t_parse_res pending_results [$];
    t_char_req  feed_q [$];
    int         err_count    = 0;
    int         cycle_count  = 0;
    int         hold_left    = 0;
    bit         hold_request = 1'b0;
    bit         calm         = 1'b0;

    localparam int DIRECTED_ROWS = 24;
    t_char_req directed_tbl [0:DIRECTED_ROWS-1] = '{
        '{8'h00,             1'b1, 1'b1, 1'b0, 32'd0},  // control byte while idle
        '{rtip_pkg::CH_MINUS, 1'b1, 1'b0, 1'b0, 32'd0},
        '{rtip_pkg::CH_SPACE, 1'b1, 1'b1, 1'b0, 32'd0}, // delimiter right after sign
        '{"0",               1'b1, 1'b0, 1'b0, 32'd0},
        '{rtip_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, 32'd0}, // lone zero
        '{rtip_pkg::CH_MINUS, 1'b1, 1'b0, 1'b0, 32'd0},
        '{"0",               1'b1, 1'b0, 1'b0, 32'd0},
        '{8'h0A,             1'b1, 1'b1, 1'b1, 32'd0},  // negative zero
        '{"0",               1'b1, 1'b0, 1'b0, 32'd0},
        '{"x",               1'b1, 1'b0, 1'b0, 32'd0},
        '{rtip_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, 32'd0}, // bare hex prefix
        '{"0",               1'b1, 1'b0, 1'b0, 32'd0},
        '{"X",               1'b1, 1'b1, 1'b0, 32'd0},  // upper-case prefix is invalid
        '{8'hFF,             1'b1, 1'b0, 1'b0, 32'd0},  // swallowed while discarding
        '{8'h1F,             1'b1, 1'b0, 1'b0, 32'd0},
        '{8'hFF,             1'b1, 1'b1, 1'b0, 32'd0},  // invalid start
        '{rtip_pkg::CH_SPACE, 1'b1, 1'b0, 1'b0, 32'd0},
        '{"0",               1'b0, 1'b0, 1'b0, 32'd0},
        '{"7",               1'b0, 1'b0, 1'b0, 32'd0},
        '{rtip_pkg::CH_SPACE, 1'b0, 1'b0, 1'b0, 32'd0},
        '{"0",               1'b0, 1'b0, 1'b0, 32'd0},
        '{"b",               1'b0, 1'b0, 1'b0, 32'd0},
        '{"1",               1'b0, 1'b0, 1'b0, 32'd0},
        '{rtip_pkg::CH_SPACE, 1'b0, 1'b0, 1'b0, 32'd0}
    };

    function automatic logic [7:0] digit_of(logic [7:0] c);
        logic [7:0] d;
        d = c;
        if (d >= rtip_pkg::CH_LOW_A) d = d - rtip_pkg::CASE_FOLD;
        d = d - rtip_pkg::CH_ZERO;
        if (d >= rtip_pkg::ALPHA_MIN) d = d - rtip_pkg::ALPHA_GAP;
        return d;
    endfunction

    function automatic logic [4:0] base_value(t_base r);
        case (r)
            BASE_HEX: return 5'd16;
            BASE_BIN: return 5'd2;
            BASE_OCT: return 5'd8;
            default:  return 5'd10;
        endcase
    endfunction

    function automatic t_char_req plain(logic [7:0] c);
        t_char_req r;
        r = '0;
        r.ch = c;
        return r;
    endfunction

    task automatic clear_scan();
        scan_phase = SCAN_IDLE;
        scan_neg   = 1'b0;
        scan_base  = BASE_DEC;
        scan_acc   = '0;
    endtask

    // first byte of a number, after the optional sign
    task automatic begin_number(input logic [7:0] c, output bit has);
        has = 1'b0;
        if (c == rtip_pkg::CH_ZERO) begin
            scan_phase = SCAN_LEAD_ZERO;
        end else if (c > rtip_pkg::CH_ZERO && c <= rtip_pkg::CH_NINE) begin
            scan_base  = BASE_DEC;
            scan_acc   = 32'(c - rtip_pkg::CH_ZERO);
            scan_phase = SCAN_DIGITS;
        end else if (c <= rtip_pkg::CH_SPACE) begin
            clear_scan();
            has = 1'b1;
        end else begin
            clear_scan();
            scan_phase = SCAN_SKIP;
            has = 1'b1;
        end
    endtask

    task automatic parse_char(input logic [7:0] c, output bit has, output bit ok,
                              output logic [31:0] val);
        logic [7:0] d;
        logic [4:0] b;
        has = 1'b0;
        ok  = 1'b0;
        val = '0;
        d   = digit_of(c);
        case (scan_phase)
            SCAN_SIGN: begin
                begin_number(c, has);
            end
            SCAN_LEAD_ZERO: begin
                if (c == rtip_pkg::CH_LOW_X) begin
                    scan_base  = BASE_HEX;
                    scan_acc   = '0;
                    scan_phase = SCAN_DIGITS;
                end else if (c == rtip_pkg::CH_LOW_B) begin
                    scan_base  = BASE_BIN;
                    scan_acc   = '0;
                    scan_phase = SCAN_DIGITS;
                end else if (c <= rtip_pkg::CH_SPACE) begin
                    clear_scan();
                    has = 1'b1;
                    ok  = 1'b1;
                end else if (c >= rtip_pkg::CH_ZERO && c <= rtip_pkg::CH_NINE
                             && d < 8'd8) begin
                    scan_base  = BASE_OCT;
                    scan_acc   = 32'(d);
                    scan_phase = SCAN_DIGITS;
                end else begin
                    clear_scan();
                    scan_phase = SCAN_SKIP;
                    has = 1'b1;
                end
            end
            SCAN_DIGITS: begin
                b = base_value(scan_base);
                if (c <= rtip_pkg::CH_SPACE) begin
                    val = scan_neg ? -scan_acc : scan_acc;
                    clear_scan();
                    has = 1'b1;
                    ok  = 1'b1;
                end else if (d < 8'(b)) begin
                    scan_acc = scan_acc * 32'(b) + 32'(d);
                end else begin
                    clear_scan();
                    scan_phase = SCAN_SKIP;
                    has = 1'b1;
                end
            end
            SCAN_SKIP: begin
                if (c <= rtip_pkg::CH_SPACE) clear_scan();
            end
            default: begin
                if (c == rtip_pkg::CH_MINUS) begin
                    scan_neg   = 1'b1;
                    scan_phase = SCAN_SIGN;
                end else if (c != rtip_pkg::CH_SPACE) begin
                    scan_neg = 1'b0;
                    begin_number(c, has);
                end
            end
        endcase
    endtask

    task automatic accept_char(input t_char_req item);
        bit          has;
        bit          ok;
        logic [31:0] val;
        t_parse_res  r;
        parse_char(item.ch, has, ok, val);
        if (item.typed) begin
            has = item.has_res;
            ok  = item.ok;
            val = item.value;
        end
        if (has) begin
            r.ok    = ok;
            r.value = val;
            pending_results.push_back(r);
        end
    endtask

    // Mostly well-formed tokens with random content; some corrupted, some noise.
    task automatic add_random_token();
        logic [7:0] tok [$];
        string      hex_set;
        t_base      rsel;
        int         n;
        int         kind;
        hex_set = "0123456789:;<=>?ABCDEFabcdef";
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 3)) feed_q.push_back(plain(8'($urandom_range(0, 255))));
            return;
        end
        repeat ($urandom_range(0, 2)) tok.push_back(rtip_pkg::CH_SPACE);
        if ($urandom_range(0, 2) == 0) tok.push_back(rtip_pkg::CH_MINUS);
        rsel = t_base'($urandom_range(0, 3));
        case (rsel)
            BASE_DEC: begin
                tok.push_back(8'("0" + $urandom_range(1, 9)));
                repeat ($urandom_range(0, 11)) tok.push_back(8'("0" + $urandom_range(0, 9)));
            end
            BASE_HEX: begin
                tok.push_back(rtip_pkg::CH_ZERO);
                tok.push_back(rtip_pkg::CH_LOW_X);
                repeat ($urandom_range(0, 10)) tok.push_back(hex_set[$urandom_range(0, 27)]);
            end
            BASE_BIN: begin
                tok.push_back(rtip_pkg::CH_ZERO);
                tok.push_back(rtip_pkg::CH_LOW_B);
                repeat ($urandom_range(0, 34)) tok.push_back(8'("0" + $urandom_range(0, 1)));
            end
            default: begin
                tok.push_back(rtip_pkg::CH_ZERO);
                repeat ($urandom_range(0, 12)) tok.push_back(8'("0" + $urandom_range(0, 7)));
            end
        endcase
        if (kind == 1) begin
            n = $urandom_range(0, tok.size());
            tok.insert(n, 8'($urandom_range(33, 255)));
        end
        tok.push_back(8'($urandom_range(0, 32)));
        foreach (tok[i]) feed_q.push_back(plain(tok[i]));
    endtask

    initial begin : stimulus
        int k;
        int drain;
        foreach (directed_tbl[i]) feed_q.push_back(directed_tbl[i]);
        while (feed_q.size() < DIRECTED_ROWS + RANDOM_CHARS) add_random_token();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < feed_q.size(); k++) begin
            if (k == HOLD_AT) hold_request = 1'b1;
            if (k >= feed_q.size() - CALM_TAIL) calm = 1'b1;
            if (!calm && hold_left == 0 && $urandom_range(0, 5) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_ch    <= feed_q[k].ch;
            do @(posedge i_clk); while (!o_ready);
            accept_char(feed_q[k]);
        end
        i_valid <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            err_count += pending_results.size();
            $display("%0t: %0d expected requests never arrived", $time,
                     pending_results.size());
        end
        if (err_count == 0) begin
            $display("radix_integer_text_parser_core_tb: clean");
        end else begin
            $display("radix_integer_text_parser_core_tb: errors");
        end
        $finish;
    end

    // output side: check each request, then pick the next ready level
    always @(posedge i_clk) begin : result_check
        t_parse_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: unexpected request: expected none, got ok=%0b value=%0d",
                         $time, o_ok, o_value);
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok) begin
                    err_count++;
                    $display("%0t: ok mismatch: expected %0b, got %0b", $time, want.ok, o_ok);
                end
                if (o_value !== want.value) begin
                    err_count++;
                    $display("%0t: value mismatch: expected %0d, got %0d", $time,
                             $signed(want.value), o_value);
                end
            end
        end
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 4);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("radix_integer_text_parser_core_tb: errors");
            $finish;
        end
    end

endmodule

/* radix_integer_text_parser_core.f */
rtl/rtip_pkg.sv
rtl/rtip_front.sv
rtl/rtip_back.sv
rtl/radix_integer_text_parser_core.sv
tb/radix_integer_text_parser_core_tb.sv
